// ===== design/binary_to_radix_ascii_string_defines.svh =====
// Assertion macros shared by the checker.
`ifndef BINARY_TO_RADIX_ASCII_STRING_DEFINES_SVH
`define BINARY_TO_RADIX_ASCII_STRING_DEFINES_SVH

// Property checked out of reset.
`define B2R_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Property checked at every edge, reset included.
`define B2R_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

// ===== design/b2r_pkg.sv =====
`timescale 1ns / 1ps
package b2r_pkg;

  localparam int unsigned FIELD_BITS = 63;
  localparam int unsigned DIGIT_BITS = 6;
  localparam int unsigned CHAR_BITS = 7;

  localparam logic [DIGIT_BITS-1:0] BASE_MIN = 6'd2;
  localparam logic [DIGIT_BITS-1:0] BASE_MAX = 6'd36;
  localparam logic [DIGIT_BITS-1:0] BASE_RESET = 6'd16;
  localparam logic [DIGIT_BITS-1:0] TEN = 6'd10;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE = 7'd57;
  localparam logic [CHAR_BITS-1:0] ASCII_A = 7'd65;
  localparam logic [CHAR_BITS-1:0] ASCII_Z = 7'd90;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic read;
  } dp_cmd_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < TEN) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A + {1'b0, d - TEN};
    end
    return c;
  endfunction

endpackage

// ===== design/b2r_datapath.sv =====
`timescale 1ns / 1ps
module b2r_datapath import b2r_pkg::*; #(
  parameter int unsigned VALUE_BITS = 63,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [ADDR_W-1:0]     addr,
  input  logic                  cfg_we,
  input  logic [DIGIT_BITS-1:0] cfg_wdata,
  input  logic [FIELD_BITS-1:0] in_value,
  output logic                  quot_zero,
  output logic [CHAR_BITS-1:0]  digit_char
);

  logic [DIGIT_BITS-1:0] cfg_base_r;
  logic [DIGIT_BITS-1:0] base_r, base_nxt;
  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [DIGIT_BITS-1:0] rem_r, rem_nxt;
  logic [DIGIT_BITS:0]   trial;
  logic                  ge;
  logic [DIGIT_BITS-1:0] rd_data_r;
  logic [DIGIT_BITS-1:0] mem [VALUE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_RESET;
    end else if (cfg_we) begin
      cfg_base_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_base_r < BASE_MIN) begin
      base_nxt = BASE_MIN;
    end else if (cfg_base_r > BASE_MAX) begin
      base_nxt = BASE_MAX;
    end else begin
      base_nxt = cfg_base_r;
    end
  end

  assign trial = {rem_r, quot_r[VALUE_BITS-1]};
  assign ge    = (trial >= {1'b0, base_r});

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (cmd.load) begin
      quot_nxt = in_value[VALUE_BITS-1:0];
      rem_nxt  = '0;
    end else if (cmd.step) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? DIGIT_BITS'(trial - {1'b0, base_r}) : trial[DIGIT_BITS-1:0];
    end else if (cmd.store) begin
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (cmd.load) begin
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[addr] <= rem_r;
    end
    if (cmd.read) begin
      rd_data_r <= mem[addr];
    end
  end

  assign quot_zero  = (quot_r == '0);
  assign digit_char = digit_to_ascii(rd_data_r);

endmodule

// ===== design/b2r_controller.sv =====
`timescale 1ns / 1ps
module b2r_controller import b2r_pkg::*; #(
  parameter int unsigned VALUE_BITS = 63,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned BIT_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              quot_zero,
  output logic              busy,
  output dp_cmd_t           cmd,
  output logic [ADDR_W-1:0] addr,
  output logic              out_strobe,
  output logic              out_last_digit
);

  localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(VALUE_BITS - 1);
  localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(VALUE_BITS - 1);

  state_t            state_r, state_nxt;
  logic [BIT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      ptr_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    ptr_nxt        = ptr_r;
    cmd            = '0;
    out_strobe     = 1'b0;
    out_last_digit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = BIT_LAST;
          ptr_nxt     = '0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = ST_STORE;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (quot_zero || ptr_r == PTR_LAST) begin
          state_nxt = ST_READ;
        end else begin
          ptr_nxt     = ptr_r + 1'b1;
          bit_cnt_nxt = BIT_LAST;
          state_nxt   = ST_DIV;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_strobe     = 1'b1;
        out_last_digit = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign addr = ptr_r;

endmodule

// ===== design/binary_to_radix_ascii_string.sv =====
// An item is taken only while idle and gives at least one digit. For each
// digit the bit-serial divider divides the value by the base and the remainder
// is stored; the digits are then read back and emitted most significant first,
// a read before each character. A new item is not taken until the last is out.
// Reset is synchronous and active low; it returns the block to idle and sets
// the base to sixteen. The receiver cannot stall the character stream.
`timescale 1ns / 1ps
module binary_to_radix_ascii_string import b2r_pkg::*; #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] in_value,
  output logic                  out_strobe,
  output logic [CHAR_BITS-1:0]  out_digit_char,
  output logic                  out_last_digit,
  input  logic                  cfg_we,
  input  logic [DIGIT_BITS-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned BIT_W  = $clog2(VALUE_BITS);

  dp_cmd_t           cmd;
  logic [ADDR_W-1:0] addr;
  logic              quot_zero;

  b2r_controller #(
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (ADDR_W),
    .BIT_W      (BIT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .quot_zero      (quot_zero),
    .busy           (busy),
    .cmd            (cmd),
    .addr           (addr),
    .out_strobe     (out_strobe),
    .out_last_digit (out_last_digit)
  );

  b2r_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (ADDR_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_value   (in_value),
    .quot_zero  (quot_zero),
    .digit_char (out_digit_char)
  );

endmodule

// ===== design/b2r_checker.sv =====
`timescale 1ns / 1ps
`include "binary_to_radix_ascii_string_defines.svh"
module b2r_checker import b2r_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input logic [CHAR_BITS-1:0] out_digit_char,
  input logic                 out_last_digit
);

  logic char_ok;

  assign char_ok = (out_digit_char >= ASCII_ZERO && out_digit_char <= ASCII_NINE) ||
                   (out_digit_char >= ASCII_A && out_digit_char <= ASCII_Z);

  `B2R_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_strobe)
  `B2R_ASSERT(a_accept_busy, start && !busy |=> busy && !out_strobe)
  `B2R_ASSERT(a_strobe_busy, out_strobe |-> busy)
  `B2R_ASSERT(a_last_ends, out_strobe && out_last_digit |=> !busy)
  `B2R_ASSERT(a_char_range, out_strobe |-> char_ok)

endmodule

bind binary_to_radix_ascii_string b2r_checker u_chk (.*);
